// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rapqt_pkg.sv =====
// Package: widths, codes and controller/datapath interface types.
`default_nettype none

package rapqt_pkg;

  localparam int USED_W           = 11;
  localparam int POS_W            = 10;
  localparam int DATA_W           = 64;
  localparam int DEFAULT_MAX_SIZE = 1024;

  localparam logic [USED_W-1:0] USED_RESET = 11'd1024;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic load;
    logic rd_l;
    logic wr_l;
    logic rd_r;
    logic wr_r;
    logic shift;
    logic rd_p;
    logic acc;
    logic out_load;
  } rapqt_cmd_t;

  typedef struct packed {
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic p_is_one;
    logic clr_last;
    logic out_busy;
  } rapqt_status_t;

endpackage

`default_nettype wire

// ===== rtl/range_add_point_query_tree.sv =====
// Top level: range add / point query segment tree with a word-wide handshake.
`default_nettype none

// Segment tree over MAX_SIZE positions (used_size of them in use), all zero
// after reset. An add word (command 0) adds delta, modulo 2^64, to every
// position from first_pos to second_pos inclusive, ends swapped if out of
// order; a query word (command 1) returns one word on value with the current
// sum at first_pos. Positions at or past the effective size clamp to the last
// position; a used_size of 0 acts as 1 and one above MAX_SIZE as MAX_SIZE.
// The tree keeps its nodes in one RAM with one read and one write port, and
// each node update is a read-modify-write. An add walks the levels bottom-up,
// updating the left end node when it is odd and the right end node when it is
// odd, then moving both ends up a level, until the ends meet; a query reads
// one node per level from its leaf to the root, adding each to the sum, and
// then loads the output register. One word is worked on at a time; a finished
// result waits in the output register while the next word is taken. After
// reset and after every used_size write the node RAM is cleared, one entry a
// cycle, through all 2*MAX_SIZE entries (2048 for 1024) while in_stall stays
// high.
module range_add_point_query_tree import rapqt_pkg::*; #(
  parameter int MAX_SIZE = DEFAULT_MAX_SIZE
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration: used_size
  input  wire logic                     cfg_wr_en,
  input  wire logic        [USED_W-1:0] cfg_wr_data,
  // input words
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     command,
  input  wire logic        [POS_W-1:0]  first_pos,
  input  wire logic        [POS_W-1:0]  second_pos,
  input  wire logic signed [DATA_W-1:0] delta,
  // result words
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed      [DATA_W-1:0] value
);

  rapqt_cmd_t    cmd;
  rapqt_status_t status;
  logic [DATA_W-1:0] value_raw;

  // sequence the walk: clear pass, add levels, query path
  rapqt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .in_valid  (in_valid),
    .command   (command),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // hold the size, node indexes, delta, running sum and node RAM
  rapqt_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .first_pos   (first_pos),
    .second_pos  (second_pos),
    .delta       (DATA_W'(delta)),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .value       (value_raw)
  );

  assign value = signed'(value_raw);

endmodule

`default_nettype wire

// ===== rtl/rapqt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rapqt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/rapqt_ctrl.sv =====
// Controller: sequences clearing, range adds and point queries.
`default_nettype none

module rapqt_ctrl import rapqt_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic          in_valid,
  input  wire logic          command,
  output logic               in_stall,
  output rapqt_cmd_t         cmd,
  input  wire rapqt_status_t status
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ADD_L = 9'b000000100,
    S_WR_L  = 9'b000001000,
    S_ADD_R = 9'b000010000,
    S_WR_R  = 9'b000100000,
    S_Q_RD  = 9'b001000000,
    S_Q_ACC = 9'b010000000,
    S_Q_OUT = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // hold the input off while busy or while a size write restarts the tree
  assign in_stall = (state != S_IDLE) || cfg_wr_en;

  always_comb begin
    state_next = state;
    cmd        = '0;
    if (cfg_wr_en) begin
      // restart the clearing pass on every size write
      cmd.clr_start = 1'b1;
      state_next    = S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          cmd.clr_step = 1'b1;
          if (status.clr_last) state_next = S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = (command == CMD_QUERY) ? S_Q_RD : S_ADD_L;
          end
        end
        S_ADD_L: begin
          if (!status.l_lt_r) begin
            state_next = S_IDLE;
          end else if (status.l_odd) begin
            cmd.rd_l   = 1'b1;
            state_next = S_WR_L;
          end else begin
            state_next = S_ADD_R;
          end
        end
        S_WR_L: begin
          cmd.wr_l   = 1'b1;
          state_next = S_ADD_R;
        end
        S_ADD_R: begin
          if (status.r_odd) begin
            cmd.rd_r   = 1'b1;
            state_next = S_WR_R;
          end else begin
            cmd.shift  = 1'b1;
            state_next = S_ADD_L;
          end
        end
        S_WR_R: begin
          cmd.wr_r   = 1'b1;
          cmd.shift  = 1'b1;
          state_next = S_ADD_L;
        end
        S_Q_RD: begin
          cmd.rd_p   = 1'b1;
          state_next = S_Q_ACC;
        end
        S_Q_ACC: begin
          cmd.acc    = 1'b1;
          state_next = status.p_is_one ? S_Q_OUT : S_Q_RD;
        end
        S_Q_OUT: begin
          if (!status.out_busy) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end
        default: begin
          state_next = S_CLEAR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rapqt_datapath.sv =====
// Datapath: size register, position clamp, node walk registers and node RAM.
`default_nettype none

module rapqt_datapath import rapqt_pkg::*; #(
  parameter int MAX_SIZE = DEFAULT_MAX_SIZE
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [USED_W-1:0]  cfg_wr_data,
  input  wire logic [POS_W-1:0]   first_pos,
  input  wire logic [POS_W-1:0]   second_pos,
  input  wire logic [DATA_W-1:0]  delta,
  input  wire rapqt_cmd_t         cmd,
  output rapqt_status_t           status,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [DATA_W-1:0]       value
);

  localparam int IDX_W  = $clog2(MAX_SIZE);
  localparam int NODE_W = IDX_W + 1;
  localparam int LW     = NODE_W + 1;
  localparam int CNT_W  = $clog2(MAX_SIZE + 1);
  localparam int EW     = (CNT_W > USED_W) ? CNT_W : USED_W;
  localparam int DEPTH  = 2 * MAX_SIZE;

  logic [USED_W-1:0] used_size;
  logic [NODE_W-1:0] clr_cnt;
  logic [LW-1:0]     node_l;
  logic [LW-1:0]     node_r;
  logic [NODE_W-1:0] node_p;
  logic [DATA_W-1:0] add_delta;
  logic [DATA_W-1:0] sum;

  logic [EW-1:0]     eff_n;
  logic [EW-1:0]     eff_last;
  logic [EW-1:0]     pos_a_ext;
  logic [EW-1:0]     pos_b_ext;
  logic [EW-1:0]     clamp_a;
  logic [EW-1:0]     clamp_b;
  logic [IDX_W-1:0]  pos_a;
  logic [IDX_W-1:0]  pos_b;
  logic [IDX_W-1:0]  pos_lo;
  logic [IDX_W-1:0]  pos_hi;
  logic [LW-1:0]     r_dec;

  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [NODE_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // effective size: zero acts as one, anything above the tree acts as full
  always_comb begin
    eff_n = EW'(used_size);
    if (eff_n == '0) begin
      eff_n = EW'(1);
    end else if (eff_n > EW'(MAX_SIZE)) begin
      eff_n = EW'(MAX_SIZE);
    end
  end

  assign eff_last  = eff_n - EW'(1);
  assign pos_a_ext = EW'(first_pos);
  assign pos_b_ext = EW'(second_pos);
  assign clamp_a   = (pos_a_ext >= eff_n) ? eff_last : pos_a_ext;
  assign clamp_b   = (pos_b_ext >= eff_n) ? eff_last : pos_b_ext;
  assign pos_a     = clamp_a[IDX_W-1:0];
  assign pos_b     = clamp_b[IDX_W-1:0];
  assign pos_lo    = (pos_a > pos_b) ? pos_b : pos_a;
  assign pos_hi    = (pos_a > pos_b) ? pos_a : pos_b;
  assign r_dec     = node_r - LW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      used_size <= USED_RESET;
    end else if (cfg_wr_en) begin
      used_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + NODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_l    <= LW'(MAX_SIZE) + LW'(pos_lo);
      node_r    <= LW'(MAX_SIZE) + LW'(pos_hi) + LW'(1);
      node_p    <= NODE_W'(MAX_SIZE) + NODE_W'(pos_a);
      add_delta <= delta;
      sum       <= '0;
    end else begin
      if (cmd.wr_l) begin
        node_l <= node_l + LW'(1);
      end
      if (cmd.rd_r) begin
        node_r <= r_dec;
      end
      if (cmd.shift) begin
        node_l <= node_l >> 1;
        node_r <= node_r >> 1;
      end
      if (cmd.acc) begin
        sum    <= sum + ram_rdata;
        node_p <= node_p >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value <= sum;
    end
  end

  always_comb begin
    ram_raddr = '0;
    if (cmd.rd_l) begin
      ram_raddr = node_l[NODE_W-1:0];
    end else if (cmd.rd_r) begin
      ram_raddr = r_dec[NODE_W-1:0];
    end else if (cmd.rd_p) begin
      ram_raddr = node_p;
    end
  end

  assign ram_we    = cmd.clr_step || cmd.wr_l || cmd.wr_r;
  assign ram_waddr = cmd.clr_step ? clr_cnt :
                     cmd.wr_r     ? node_r[NODE_W-1:0] : node_l[NODE_W-1:0];
  assign ram_wdata = cmd.clr_step ? '0 : (ram_rdata + add_delta);

  rapqt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status.l_lt_r   = (node_l < node_r);
  assign status.l_odd    = node_l[0];
  assign status.r_odd    = node_r[0];
  assign status.p_is_one = (node_p == NODE_W'(1));
  assign status.clr_last = (clr_cnt == NODE_W'(DEPTH - 1));
  assign status.out_busy = out_valid && out_stall;

endmodule

`default_nettype wire

// ===== rtl/rapqt_checker.sv =====
// Port-level checker for the segment tree top level, with its bind.
`default_nettype none
`include "assert_macros.svh"

module rapqt_checker import rapqt_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     cfg_wr_en,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic signed [DATA_W-1:0] value
);

  // a stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
               out_valid && $stable(value), "stalled result changed")

  // an accepted word keeps the block busy for at least the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall,
               "accepted two words back to back")

  // a size write starts the clearing pass
  `ASSERT_NEXT(a_clear_after_cfg, clk, rst, cfg_wr_en, in_stall,
               "input taken right after size write")

  // leaving reset starts the clearing pass
  `ASSERT_ALWAYS(a_clear_after_rst, clk, $past(rst) && !rst, in_stall,
                 "input taken right after reset")

endmodule

bind range_add_point_query_tree rapqt_checker u_checker (.*);

`default_nettype wire
